[design/deq_pkg.sv]
package deq_pkg;

    localparam int WORD_W = 64;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;  // beat accepted: update pointers, write store
        logic rd;    // read both ends of the run
    } t_deq_cmd;

endpackage

[design/double_ended_queue_top.sv]
// Bounded double-ended queue of DEPTH words of ELEMENT_BITS bits, kept as a
// run of entries in a ring store starting at a head pointer. Each input beat
// carries one op: push front, push back, pop front, pop back or reverse.
// Reverse only toggles a direction flag, so front and back swap with no data
// movement. Every input beat yields exactly one output beat with the new
// front and back words (zero-extended, zero when empty), the entry count, an
// empty flag and a status: ok, push refused because full, or pop refused
// because empty. A refused op leaves the queue untouched. Op codes five to
// seven are ignored and report the unchanged queue with status ok.
// Each item passes through the accept cycle, a read cycle and the cycle that
// offers the result, which is held while the output is stalled. No new
// input beat is taken until the output beat has been accepted; the next
// input beat can be taken the cycle after the output beat is accepted.
// The accept cycle moves the pointers and writes at most one entry, the read
// cycle reads both ends of the run through the two registered read ports,
// and the result cycle presents the registered result. No input beat is
// taken during reset. No clearing pass is needed after reset; entries
// outside the stored run are read only when the queue is empty, and then
// the front and back outputs are forced to zero.
module double_ended_queue_top #(
    parameter int    DEPTH        = 16,
    parameter int    ELEMENT_BITS = 64,
    localparam int   CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_op,
    input  logic [deq_pkg::WORD_W-1:0] i_push_value,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [deq_pkg::WORD_W-1:0] o_front_value,
    output logic [deq_pkg::WORD_W-1:0] o_back_value,
    output logic [CNT_W-1:0]           o_entry_count,
    output logic                       o_is_empty,
    output logic [1:0]                 o_status
);
    import deq_pkg::*;

    t_deq_cmd cmd;

    // sequencer: idle -> read -> hold result until taken
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // pointers, count, direction flag and the ring store
    deq_dpath #(
        .DEPTH        (DEPTH),
        .ELEMENT_BITS (ELEMENT_BITS),
        .CNT_W        (CNT_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

endmodule

[design/deq_ctrl.sv]
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_deq_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/deq_dpath.sv]
module deq_dpath #(
    parameter int DEPTH        = 16,
    parameter int ELEMENT_BITS = 64,
    parameter int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  deq_pkg::t_deq_cmd            i_cmd,
    input  logic [2:0]                   i_op,
    input  logic [deq_pkg::WORD_W-1:0]   i_push_value,
    output logic [deq_pkg::WORD_W-1:0]   o_front_value,
    output logic [deq_pkg::WORD_W-1:0]   o_back_value,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic                         o_is_empty,
    output logic [1:0]                   o_status
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = CNT_W + 1;

    logic [ELEMENT_BITS-1:0] r_mem [DEPTH];

    logic [AW-1:0]    r_head;
    logic [CNT_W-1:0] r_count;
    logic             r_rev;
    t_status          r_status;
    logic [ELEMENT_BITS-1:0] r_low_q;
    logic [ELEMENT_BITS-1:0] r_high_q;

    logic [AW-1:0]    n_head;
    logic [CNT_W-1:0] n_count;
    logic             n_rev;
    t_status          n_status;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    head_prev;
    logic [AW-1:0]    head_next;
    logic [AW-1:0]    tail_slot;   // one past the high end
    logic [AW-1:0]    high_slot;   // high end of the run
    logic [SW-1:0]    sum_t;
    logic [SW-1:0]    sum_h;
    logic             full;
    logic             empty;
    logic             to_low;
    t_op              op;

    assign op    = t_op'(i_op);
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // ring pointer arithmetic, all operands stay below 2*DEPTH
    always_comb begin
        head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

        sum_t = SW'(r_head) + SW'(r_count);
        if (sum_t >= SW'(DEPTH)) begin
            sum_t = sum_t - SW'(DEPTH);
        end
        tail_slot = sum_t[AW-1:0];

        sum_h = SW'(r_head) + SW'(r_count) - SW'(1);
        if (sum_h >= SW'(DEPTH)) begin
            sum_h = sum_h - SW'(DEPTH);
        end
        high_slot = empty ? r_head : sum_h[AW-1:0];
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = tail_slot;
        to_low   = 1'b0;
        unique case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                to_low = (op == OP_PUSH_FRONT) ^ r_rev;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (to_low) begin
                        n_head  = head_prev;
                        wr_addr = head_prev;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                to_low = (op == OP_POP_FRONT) ^ r_rev;
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (to_low) begin
                        n_head = head_next;
                    end
                end
            end
            OP_REVERSE: begin
                n_rev = ~r_rev;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= i_push_value[ELEMENT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_low_q  <= r_mem[r_head];
            r_high_q <= r_mem[high_slot];
        end
    end

    always_comb begin
        o_front_value = '0;
        o_back_value  = '0;
        if (!empty) begin
            o_front_value[ELEMENT_BITS-1:0] = r_rev ? r_high_q : r_low_q;
            o_back_value[ELEMENT_BITS-1:0]  = r_rev ? r_low_q : r_high_q;
        end
    end

    assign o_entry_count = r_count;
    assign o_is_empty    = empty;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < (AW + 1)'(DEPTH))
        else $error("head pointer out of range");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
        |=> (r_status == ST_FULL && $stable(r_count) && $stable(r_head)))
        else $error("refused push changed the queue");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && empty && (op == OP_POP_FRONT || op == OP_POP_BACK))
        |=> (r_status == ST_EMPTY && $stable(r_count) && $stable(r_head)))
        else $error("refused pop changed the queue");
`endif

endmodule
